// ===== src/urd_pkg.sv =====
// Shared types and constants for the unsigned restoring divider.
package urd_pkg;

  // Operand widths
  localparam int unsigned WIDE_W   = 64;
  localparam int unsigned NARROW_W = 32;
  // Iteration counter must hold WIDE_W itself
  localparam int unsigned CNT_W    = $clog2(WIDE_W + 1);

  // Width codes carried on the opcode field
  localparam logic OP_WIDE   = 1'b0;
  localparam logic OP_NARROW = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture a new item
    logic step;  // run one shift-subtract iteration
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic den_zero;  // divisor of the incoming item is zero in its width
  } status_t;

endpackage

// ===== src/urd_if.sv =====
// Valid/ready channel interfaces for divider items and results.
interface urd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [urd_pkg::WIDE_W-1:0]      dividend;
  logic [urd_pkg::WIDE_W-1:0]      divisor;

  modport source (output valid, output opcode, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input opcode, input dividend, input divisor,
                  output ready);
endinterface

interface urd_out_if;
  logic                            valid;
  logic                            ready;
  logic [urd_pkg::WIDE_W-1:0]      quotient;
  logic [urd_pkg::WIDE_W-1:0]      remainder;
  logic                            divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

// ===== src/urd_datapath.sv =====
// Shared shift-subtract unit: partial remainder, dividend/quotient shifter.
module urd_datapath (
  input  logic                        clk,
  input  logic                        opcode,
  input  logic [urd_pkg::WIDE_W-1:0]  dividend,
  input  logic [urd_pkg::WIDE_W-1:0]  divisor,
  input  urd_pkg::ctrl_t              ctrl,
  output urd_pkg::status_t            status,
  output logic [urd_pkg::WIDE_W-1:0]  quotient,
  output logic [urd_pkg::WIDE_W-1:0]  remainder,
  output logic                        divide_by_zero
);

  localparam int unsigned W  = urd_pkg::WIDE_W;
  localparam int unsigned NW = urd_pkg::NARROW_W;

  logic [W-1:0] part_r, part_nxt;   // partial remainder
  logic [W-1:0] numq_r, numq_nxt;   // dividend bits out the top, quotient bits in
  logic [W-1:0] den_r,  den_nxt;
  logic         dbz_r,  dbz_nxt;

  logic [W-1:0] num_sel, den_sel;
  logic [W:0]   shifted, diff;
  logic         den_zero;

  // Operand select; narrow dividend sits at the top so it shifts out first
  always_comb begin
    if (opcode == urd_pkg::OP_NARROW) begin
      num_sel = {dividend[NW-1:0], {(W-NW){1'b0}}};
      den_sel = {{(W-NW){1'b0}}, divisor[NW-1:0]};
    end else begin
      num_sel = dividend;
      den_sel = divisor;
    end
    den_zero = (den_sel == '0);
  end

  // One restoring step: 65-bit trial subtract, borrow decides the bit
  always_comb begin
    shifted = {part_r, numq_r[W-1]};
    diff    = shifted - {1'b0, den_r};
  end

  always_comb begin
    part_nxt = part_r;
    numq_nxt = numq_r;
    den_nxt  = den_r;
    dbz_nxt  = dbz_r;
    if (ctrl.load) begin
      den_nxt = den_sel;
      dbz_nxt = den_zero;
      if (den_zero) begin
        // Divide by zero: quotient 0, remainder is the dividend as selected
        part_nxt = (opcode == urd_pkg::OP_NARROW) ?
                   {{(W-NW){1'b0}}, dividend[NW-1:0]} : dividend;
        numq_nxt = '0;
      end else begin
        part_nxt = '0;
        numq_nxt = num_sel;
      end
    end else if (ctrl.step) begin
      if (!diff[W]) begin
        part_nxt = diff[W-1:0];
        numq_nxt = {numq_r[W-2:0], 1'b1};
      end else begin
        part_nxt = shifted[W-1:0];
        numq_nxt = {numq_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    numq_r <= numq_nxt;
    den_r  <= den_nxt;
    dbz_r  <= dbz_nxt;
  end

  assign status.den_zero = den_zero;
  assign quotient        = numq_r;
  assign remainder       = part_r;
  assign divide_by_zero  = dbz_r;

endmodule

// ===== src/urd_ctrl.sv =====
// Sequencer: accepts an item, counts iterations, holds the result for delivery.
module urd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        opcode,
  input  logic                        out_ready,
  input  urd_pkg::status_t            status,
  output logic                        in_ready,
  output logic                        out_valid,
  output urd_pkg::ctrl_t              ctrl
);

  localparam int unsigned CW = urd_pkg::CNT_W;

  urd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= urd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctrl      = '0;
    unique case (state_r)
      urd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          cnt_nxt   = (opcode == urd_pkg::OP_NARROW) ?
                      CW'(urd_pkg::NARROW_W) : CW'(urd_pkg::WIDE_W);
          state_nxt = status.den_zero ? urd_pkg::ST_DONE : urd_pkg::ST_RUN;
        end
      end
      urd_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = urd_pkg::ST_DONE;
        end
      end
      urd_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = urd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = urd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/unsigned_restoring_divider_unit.sv =====
// Unsigned restoring divider, 64-bit or 32-bit, one quotient bit per cycle.
// An item is loaded, then runs 64 iterations (opcode 0) or 32
// iterations (opcode 1) of a single 65-bit trial subtract, after which the
// result is held on the output until taken; the block accepts the next item
// the cycle after the result leaves.
// A zero divisor skips the iterations: divide_by_zero is set, quotient is 0
// and remainder is the dividend in the selected width. In 32-bit mode the
// upper 32 bits of both operands are ignored and results are zero-extended.
module unsigned_restoring_divider_unit (
  input  logic        clk,
  input  logic        rst_n,
  urd_in_if.sink      in_if,
  urd_out_if.source   out_if
);

  urd_pkg::ctrl_t   ctrl;
  urd_pkg::status_t status;

  // Sequencer
  urd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .opcode    (in_if.opcode),
    .out_ready (out_if.ready),
    .status    (status),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .ctrl      (ctrl)
  );

  // Shift-subtract unit
  urd_datapath u_datapath (
    .clk            (clk),
    .opcode         (in_if.opcode),
    .dividend       (in_if.dividend),
    .divisor        (in_if.divisor),
    .ctrl           (ctrl),
    .status         (status),
    .quotient       (out_if.quotient),
    .remainder      (out_if.remainder),
    .divide_by_zero (out_if.divide_by_zero)
  );

endmodule
